// File: rtl/core/sjt_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the sorted job table
package sjt_pkg;

  localparam int DEF_MAX_JOBS = 64;
  localparam int DEF_CNT_W    = $clog2(DEF_MAX_JOBS + 1);

  localparam int OP_W   = 2;
  localparam int KEY_W  = 32;
  localparam int WALL_W = 31;
  localparam int TIME_W = 63;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [WALL_W-1:0] wall;
    logic [TIME_W-1:0] submit;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic insert;
    logic remove;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            hit;
    logic            full;
  } dp_stat_t;

  // smallest g with g*g >= n, evaluated at elaboration
  function automatic int ceil_sqrt(input int n);
    int g;
    g = 1;
    while (g * g < n) g++;
    return g;
  endfunction

endpackage

// File: rtl/core/sjt_in_if.sv
`timescale 1ns / 1ps
// request channel of the sorted job table
interface sjt_in_if import sjt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [KEY_W-1:0]  job_key;
  logic [WALL_W-1:0] job_walltime;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, op, job_key, job_walltime, now_time, input ready);
  modport sink   (input valid, op, job_key, job_walltime, now_time, output ready);
endinterface

// File: rtl/core/sjt_out_if.sv
`timescale 1ns / 1ps
// result channel of the sorted job table
interface sjt_out_if import sjt_pkg::*; #(parameter int CNT_W = DEF_CNT_W) ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [WALL_W-1:0] found_walltime;
  logic [TIME_W-1:0] found_submit_time;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, status, found_walltime, found_submit_time, entry_count,
                  input ready);
  modport sink   (input valid, status, found_walltime, found_submit_time, entry_count,
                  output ready);
endinterface

// File: rtl/core/sjt_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine of the sorted job table
module sjt_ctrl import sjt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_L1   = 2'd1;
  localparam logic [1:0] S_L2   = 2'd2;
  localparam logic [1:0] S_ACT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       fire;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  // result register is free, or is being emptied this cycle
  assign fire      = (state_r == S_ACT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.capture  = accept;
    cmd.out_load = fire;
    cmd.insert   = fire && (stat.op == OP_INSERT) && !stat.full;
    cmd.remove   = fire && (stat.op == OP_REMOVE) && stat.hit;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_L1;
      S_L1:   state_nxt = S_L2;
      S_L2:   state_nxt = S_ACT;
      S_ACT:  if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_L1)
    else $error("accepted word did not enter the compare sequence");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACT && !fire) |=> (state_r == S_ACT && out_valid_r))
    else $error("finished word left while the result register was blocked");

  a_remove_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |-> (stat.hit && stat.op == OP_REMOVE && !cmd.insert))
    else $error("table shifted down without a matching entry");

endmodule

// File: rtl/core/sjt_datapath.sv
`timescale 1ns / 1ps
// sorted cell chain, match reduction tree and result register
module sjt_datapath import sjt_pkg::*; #(
  parameter int MAX_JOBS = DEF_MAX_JOBS,
  parameter int CNT_W    = $clog2(MAX_JOBS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  input  logic [OP_W-1:0]   in_op,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [WALL_W-1:0] in_wall,
  input  logic [TIME_W-1:0] in_now,
  output logic [ST_W-1:0]   out_status,
  output logic [WALL_W-1:0] out_wall,
  output logic [TIME_W-1:0] out_submit,
  output logic [CNT_W-1:0]  out_count
);

  localparam int GRP  = ceil_sqrt(MAX_JOBS);
  localparam int NGRP = (MAX_JOBS + GRP - 1) / GRP;

  entry_t            cell_r [MAX_JOBS];
  entry_t            prv_w  [MAX_JOBS];
  entry_t            nxt_w  [MAX_JOBS];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [OP_W-1:0]   op_r;
  entry_t            new_r;
  logic [MAX_JOBS-1:0] lt_r, eq_r, first_hit, ins_pos;

  logic [NGRP-1:0]   hit_l1_r;
  logic [WALL_W-1:0] wall_l1_r [NGRP];
  logic [TIME_W-1:0] sub_l1_r  [NGRP];
  logic              hit_l2_r;
  logic [WALL_W-1:0] wall_l2_r;
  logic [TIME_W-1:0] sub_l2_r;

  logic              full;
  logic [ST_W-1:0]   status_nxt;

  logic [ST_W-1:0]   status_r;
  logic [WALL_W-1:0] fw_r;
  logic [TIME_W-1:0] fs_r;
  logic [CNT_W-1:0]  cnt_out_r;

  assign full      = (count_r == CNT_W'(MAX_JOBS));
  assign stat.op   = op_r;
  assign stat.hit  = hit_l2_r;
  assign stat.full = full;

  // capture the request and compare its key against every live cell
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r         <= in_op;
      new_r.key    <= in_key;
      new_r.wall   <= in_wall;
      new_r.submit <= in_now;
    end
  end

  genvar i;
  generate
    for (i = 0; i < MAX_JOBS; i++) begin : g_cell
      always_ff @(posedge clk) begin
        if (cmd.capture) begin
          lt_r[i] <= (CNT_W'(i) < count_r) && (cell_r[i].key < in_key);
          eq_r[i] <= (CNT_W'(i) < count_r) && (cell_r[i].key == in_key);
        end
      end

      // table is sorted, so the first match and the insert slot are local
      if (i == 0) begin : g_head
        assign first_hit[i] = eq_r[i];
        assign ins_pos[i]   = !lt_r[i];
        assign prv_w[i]     = cell_r[i];
      end else begin : g_body
        assign first_hit[i] = eq_r[i] && !eq_r[i-1];
        assign ins_pos[i]   = !lt_r[i] && lt_r[i-1];
        assign prv_w[i]     = cell_r[i-1];
      end

      if (i == MAX_JOBS - 1) begin : g_tail
        assign nxt_w[i] = cell_r[i];
      end else begin : g_mid
        assign nxt_w[i] = cell_r[i+1];
      end

      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (ins_pos[i]) begin
            cell_r[i] <= new_r;
          end else if (!lt_r[i]) begin
            cell_r[i] <= prv_w[i];
          end
        end else if (cmd.remove && !lt_r[i]) begin
          cell_r[i] <= nxt_w[i];
        end
      end
    end
  endgenerate

  // first level of the match tree: one group of cells per register
  genvar g, j;
  generate
    for (g = 0; g < NGRP; g++) begin : g_grp
      logic [GRP-1:0]    hit_w;
      logic [WALL_W-1:0] wall_w [GRP];
      logic [TIME_W-1:0] sub_w  [GRP];
      logic [WALL_W-1:0] wall_or;
      logic [TIME_W-1:0] sub_or;

      for (j = 0; j < GRP; j++) begin : g_leaf
        if (g * GRP + j < MAX_JOBS) begin : g_live
          assign hit_w[j]  = first_hit[g*GRP+j];
          assign wall_w[j] = first_hit[g*GRP+j] ? cell_r[g*GRP+j].wall : '0;
          assign sub_w[j]  = first_hit[g*GRP+j] ? cell_r[g*GRP+j].submit : '0;
        end else begin : g_pad
          assign hit_w[j]  = 1'b0;
          assign wall_w[j] = '0;
          assign sub_w[j]  = '0;
        end
      end

      always_comb begin
        wall_or = '0;
        sub_or  = '0;
        for (int k = 0; k < GRP; k++) begin
          wall_or = wall_or | wall_w[k];
          sub_or  = sub_or | sub_w[k];
        end
      end

      always_ff @(posedge clk) begin
        hit_l1_r[g]  <= |hit_w;
        wall_l1_r[g] <= wall_or;
        sub_l1_r[g]  <= sub_or;
      end
    end
  endgenerate

  // second level of the match tree
  always_ff @(posedge clk) begin
    logic [WALL_W-1:0] w_acc;
    logic [TIME_W-1:0] s_acc;
    w_acc = '0;
    s_acc = '0;
    for (int k = 0; k < NGRP; k++) begin
      w_acc = w_acc | wall_l1_r[k];
      s_acc = s_acc | sub_l1_r[k];
    end
    hit_l2_r  <= |hit_l1_r;
    wall_l2_r <= w_acc;
    sub_l2_r  <= s_acc;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.remove) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    unique case (op_r) inside
      OP_INSERT:          status_nxt = full ? ST_FULL : ST_DONE;
      OP_REMOVE, OP_FIND: status_nxt = hit_l2_r ? ST_DONE : ST_NOT_FOUND;
      default:            status_nxt = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r  <= status_nxt;
      fw_r      <= (op_r == OP_FIND && hit_l2_r) ? wall_l2_r : '0;
      fs_r      <= (op_r == OP_FIND && hit_l2_r) ? sub_l2_r : '0;
      cnt_out_r <= count_nxt;
    end
  end

  assign out_status = status_r;
  assign out_wall   = fw_r;
  assign out_submit = fs_r;
  assign out_count  = cnt_out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_JOBS))
    else $error("entry count beyond table size");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("insert did not grow the table by one");

  a_single_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> $onehot(ins_pos))
    else $error("insert slot not unique");

endmodule

// File: rtl/core/sorted_job_table_top.sv
`timescale 1ns / 1ps
// top level of the sorted job table
// Keeps up to MAX_JOBS jobs sorted by id in a chain of cells, one entry per
// cell, and answers every insert, remove or find word with one result word.
// The key is compared against all cells at once in the accepting cycle. A
// registered match tree, first level and then second level, then picks out
// the first matching cell. The chain is then shifted and the result register
// loaded in the same cycle, once the result register is free. The next word
// is taken in the cycle after that, so a new word is not accepted until the
// previous one is through. The result may still wait on the output while the
// next word is being worked on. If the previous result is still held when the
// next one finishes, that word waits until it is taken.
// The out channel's entry_count width must be $clog2(MAX_JOBS + 1).
module sorted_job_table_top import sjt_pkg::*; #(
  parameter int MAX_JOBS = DEF_MAX_JOBS
) (
  input  logic      clk,
  input  logic      rst_n,
  sjt_in_if.sink    in_ch,
  sjt_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sjt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sjt_datapath #(
    .MAX_JOBS (MAX_JOBS),
    .CNT_W    (CNT_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_ch.op),
    .in_key     (in_ch.job_key),
    .in_wall    (in_ch.job_walltime),
    .in_now     (in_ch.now_time),
    .out_status (out_ch.status),
    .out_wall   (out_ch.found_walltime),
    .out_submit (out_ch.found_submit_time),
    .out_count  (out_ch.entry_count)
  );

endmodule

// File: verif/sorted_job_table_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the sorted job table: directed table, then random job traffic
module sorted_job_table_top_tb;
  import sjt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int NUM_DIRECTED = 24;
  localparam int PHASE_ITEMS  = 667;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT      = NUM_DIRECTED + 2 * PHASE_ITEMS + 50;

  localparam int EP_FILL  = 0;
  localparam int EP_DRAIN = 1;
  localparam int EP_MIXED = 2;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [WALL_W-1:0]    wall;
    logic [TIME_W-1:0]    submit;
    logic [DEF_CNT_W-1:0] count;
  } job_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [WALL_W-1:0] wall;
    logic [TIME_W-1:0] now;
    logic              has_exp;
    job_result_t       exp;
  } job_word_t;

  logic clk;
  logic rst_n;

  sjt_in_if  in_if ();
  sjt_out_if out_if ();

  sorted_job_table_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predicted contents of the table, ascending by key
  entry_t      job_table[$];
  job_result_t expected_results[$];
  job_word_t   directed_words [NUM_DIRECTED];

  logic        word_has_exp;
  job_result_t word_exp;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int results_checked;
  int full_refusals;
  int not_found_count;
  int peak_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("sorted_job_table_top_tb failed");
    $finish;
  end

  function automatic int first_job_index(logic [KEY_W-1:0] key);
    for (int i = 0; i < job_table.size(); i++)
      if (job_table[i].key == key) return i;
    return -1;
  endfunction

  function automatic job_result_t apply_job_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                                 logic [WALL_W-1:0] wall,
                                                 logic [TIME_W-1:0] now);
    job_result_t r;
    entry_t      e;
    int          pos;
    r = '0;
    r.status = ST_DONE;
    case (op)
      OP_INSERT: begin
        if (job_table.size() >= DEF_MAX_JOBS) begin
          r.status = ST_FULL;
        end else begin
          // newest duplicate goes ahead of older ones
          pos = 0;
          while (pos < job_table.size() && job_table[pos].key < key) pos++;
          e.key    = key;
          e.wall   = wall;
          e.submit = now;
          job_table.insert(pos, e);
        end
      end
      OP_REMOVE: begin
        pos = first_job_index(key);
        if (pos < 0) r.status = ST_NOT_FOUND;
        else job_table.delete(pos);
      end
      OP_FIND: begin
        pos = first_job_index(key);
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.wall   = job_table[pos].wall;
          r.submit = job_table[pos].submit;
        end
      end
      default: ;
    endcase
    r.count = DEF_CNT_W'(job_table.size());
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_job_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(15);
    if (r < 55) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return '1;
        2:       return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  task automatic offer_word(input job_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid        = 1'b1;
    in_if.op           = w.op;
    in_if.job_key      = w.key;
    in_if.job_walltime = w.wall;
    in_if.now_time     = w.now;
    word_has_exp       = w.has_exp;
    word_exp           = w.exp;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // result checking and prediction, both sampled at the rising edge
  always @(posedge clk) begin : scoreboard
    job_result_t want;
    job_result_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.status, out_if.found_walltime, out_if.found_submit_time,
                out_if.entry_count};
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
          end
          if (got.wall !== want.wall) begin
            $error("found_walltime: expected %0h, got %0h", want.wall, got.wall);
            mismatch_count++;
          end
          if (got.submit !== want.submit) begin
            $error("found_submit_time: expected %0h, got %0h", want.submit, got.submit);
            mismatch_count++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, got.count);
            mismatch_count++;
          end
        end
        results_checked++;
        if (got.status == ST_FULL) full_refusals++;
        if (got.status == ST_NOT_FOUND) not_found_count++;
        if (int'(got.count) > peak_count) peak_count = int'(got.count);
      end
      if (in_if.valid && in_if.ready) begin
        want = apply_job_word(in_if.op, in_if.job_key, in_if.job_walltime, in_if.now_time);
        if (word_has_exp) want = word_exp;
        expected_results.push_back(want);
      end
    end
  end

  // result side: random stalls, plus one long hold-off to back the block up
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && results_checked >= HOLD_AT) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    job_word_t   w;
    int          items_left;
    int          ep_len;
    int          ep_kind;
    int          ins_pct;
    int          rem_share;
    int unsigned r;
    logic [31:0] rnd32;
    logic [63:0] rnd64;

    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.op           = OP_INSERT;
    in_if.job_key      = '0;
    in_if.job_walltime = '0;
    in_if.now_time     = '0;
    word_has_exp       = 1'b0;
    word_exp           = '0;
    send_idle_pct      = 15;
    recv_idle_pct      = 52;
    mismatch_count     = 0;
    results_checked    = 0;
    full_refusals      = 0;
    not_found_count    = 0;
    peak_count         = 0;

    directed_words = '{
      '{OP_FIND,   32'h0,         31'h0,         63'h0, 1'b1,
        '{ST_NOT_FOUND, 31'h0, 63'h0, 7'd0}},
      '{OP_REMOVE, 32'hFFFF_FFFF, 31'h0,         63'h0, 1'b1,
        '{ST_NOT_FOUND, 31'h0, 63'h0, 7'd0}},
      '{OP_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1,
        '{ST_DONE, 31'h0, 63'h0, 7'd0}},
      '{OP_INSERT, 32'h0,         31'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1,
        '{ST_DONE, 31'h0, 63'h0, 7'd1}},
      '{OP_FIND,   32'h0,         31'h0,         63'h0, 1'b1,
        '{ST_DONE, 31'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 7'd1}},
      '{OP_INSERT, 32'hFFFF_FFFF, 31'h0,         63'h0, 1'b1,
        '{ST_DONE, 31'h0, 63'h0, 7'd2}},
      '{OP_FIND,   32'hFFFF_FFFF, 31'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1,
        '{ST_DONE, 31'h0, 63'h0, 7'd2}},
      // duplicate keys: the newer entry must be seen first
      '{OP_INSERT, 32'd5,         31'd1,         63'd100, 1'b0, '0},
      '{OP_INSERT, 32'd5,         31'd2,         63'd200, 1'b0, '0},
      '{OP_FIND,   32'd5,         31'h0,         63'h0,   1'b0, '0},
      '{OP_REMOVE, 32'd5,         31'h0,         63'h0,   1'b0, '0},
      '{OP_FIND,   32'd5,         31'h0,         63'h0,   1'b0, '0},
      '{OP_INSERT, 32'h8000_0000, 31'h2AAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, '0},
      '{OP_INSERT, 32'h7FFF_FFFF, 31'h5555_5555, 63'h5555_5555_5555_5555, 1'b0, '0},
      '{OP_FIND,   32'h8000_0000, 31'h0,         63'h0,   1'b0, '0},
      '{OP_FIND,   32'h7FFF_FFFF, 31'h0,         63'h0,   1'b0, '0},
      '{OP_REMOVE, 32'd1,         31'h0,         63'h0,   1'b0, '0},
      '{OP_UNUSED, 32'd5,         31'h5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, '0},
      '{OP_REMOVE, 32'h0,         31'h0,         63'h0,   1'b0, '0},
      '{OP_REMOVE, 32'hFFFF_FFFF, 31'h0,         63'h0,   1'b0, '0},
      '{OP_REMOVE, 32'd5,         31'h0,         63'h0,   1'b0, '0},
      '{OP_REMOVE, 32'h8000_0000, 31'h0,         63'h0,   1'b0, '0},
      '{OP_REMOVE, 32'h7FFF_FFFF, 31'h0,         63'h0,   1'b0, '0},
      '{OP_FIND,   32'h7FFF_FFFF, 31'h0,         63'h0,   1'b1,
        '{ST_NOT_FOUND, 31'h0, 63'h0, 7'd0}}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_words[i]) offer_word(directed_words[i]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 15; recv_idle_pct = 52; end
        1:       begin send_idle_pct = 52; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      items_left = PHASE_ITEMS;
      while (items_left > 0) begin
        // every phase opens with a fill run so the full case is hit under each pacing
        if (items_left == PHASE_ITEMS) ep_kind = EP_FILL;
        else ep_kind = $urandom_range(EP_MIXED);
        case (ep_kind)
          EP_FILL:  begin ins_pct = 85; rem_share = 50; ep_len = $urandom_range(100, 140); end
          EP_DRAIN: begin ins_pct = 10; rem_share = 80; ep_len = $urandom_range(20, 120);  end
          default:  begin ins_pct = 40; rem_share = 50; ep_len = $urandom_range(20, 120);  end
        endcase
        while (ep_len > 0 && items_left > 0) begin
          r = $urandom_range(99);
          if (r < 2) w.op = OP_UNUSED;
          else if (r < 2 + ins_pct) w.op = OP_INSERT;
          else if ($urandom_range(99) < rem_share) w.op = OP_REMOVE;
          else w.op = OP_FIND;
          if (w.op != OP_INSERT && job_table.size() > 0 && $urandom_range(99) < 75)
            w.key = job_table[$urandom_range(job_table.size() - 1)].key;
          else
            w.key = pick_job_key();
          rnd32 = $urandom;
          w.wall = ($urandom_range(9) == 0) ? '1 : rnd32[WALL_W-1:0];
          rnd64 = {$urandom, $urandom};
          w.now = ($urandom_range(19) == 0) ? '1 : rnd64[TIME_W-1:0];
          w.has_exp = 1'b0;
          w.exp     = '0;
          offer_word(w);
          ep_len--;
          items_left--;
        end
      end
    end
    in_if.valid = 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("checked %0d result words over %0d directed and %0d random jobs",
             results_checked, NUM_DIRECTED, 3 * PHASE_ITEMS);
    $display("table full refusals %0d, misses %0d, peak occupancy %0d of %0d",
             full_refusals, not_found_count, peak_count, DEF_MAX_JOBS);
    if (mismatch_count == 0) begin
      $display("sorted_job_table_top_tb passed");
    end else begin
      $display("sorted_job_table_top_tb failed");
    end
    $finish;
  end

endmodule
